>>> rtl/hourly_light_schedule_interpolator_macros.svh
// Assertion macros shared by the schedule interpolator RTL.
`ifndef HOURLY_LIGHT_SCHEDULE_INTERPOLATOR_MACROS_SVH
`define HOURLY_LIGHT_SCHEDULE_INTERPOLATOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define HLSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define HLSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hlsi_pkg.sv
// Types, constants and helper functions for the schedule interpolator.
package hlsi_pkg;

  localparam int HOURS_DEF  = 24;
  localparam int NUM_CH     = 3;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int TEMP_W     = 12;
  localparam int DUTY_W     = 10;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd1000;
  localparam logic [MIN_W-1:0]  PROG_FULL = 6'd60;

  // floor(x / 60) for x < 2^16 as (x * RECIP_60) >> RECIP_60_SHIFT, exact
  localparam int PROD_W         = 16;
  localparam int Q_W            = 11;
  localparam int RECIP_W        = 17;
  localparam int RECIP_60       = 69906;
  localparam int RECIP_60_SHIFT = 22;

  // fan mapping, tenths of a degree
  localparam int FAN_ON_TENTHS   = 400;
  localparam int FAN_FULL_TENTHS = 600;
  localparam int FAN_U_W         = 8;
  localparam int FAN_Q_W         = 5;
  localparam int RECIP_10        = 205;
  localparam int RECIP_10_SHIFT  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FAN_MANUAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_DUTY   = 1'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_PREVIEW = 2'd2
  } action_t;

  typedef enum logic {
    MODE_LIVE,
    MODE_PREVIEW
  } mode_t;

  // per-tick lookup, worked out at acceptance
  typedef struct packed {
    logic [HOUR_W-1:0] row;
    logic [HOUR_W-1:0] nxt;
    logic [MIN_W-1:0]  prog;
    logic              pon;
  } tick_info_t;

  typedef struct packed {
    logic [NUM_CH-1:0] en;
    logic [HOUR_W-1:0] row;
  } tbl_wr_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  localparam logic [DUTY_W-1:0] DEFAULT_PROFILE [HOURS_DEF][NUM_CH] = '{
    '{10'd0,    10'd0,    10'd0},    '{10'd0,    10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd0},    '{10'd0,    10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd0},    '{10'd0,    10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd0},    '{10'd0,    10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd0},    '{10'd200,  10'd200,  10'd0},
    '{10'd500,  10'd500,  10'd200},  '{10'd900,  10'd900,  10'd300},
    '{10'd1000, 10'd1000, 10'd1000}, '{10'd1000, 10'd1000, 10'd800},
    '{10'd900,  10'd900,  10'd500},  '{10'd800,  10'd800,  10'd300},
    '{10'd700,  10'd800,  10'd300},  '{10'd600,  10'd800,  10'd300},
    '{10'd500,  10'd800,  10'd300},  '{10'd400,  10'd400,  10'd250},
    '{10'd300,  10'd300,  10'd300},  '{10'd0,    10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd0},    '{10'd0,    10'd0,    10'd0}
  };

  function automatic logic [DUTY_W-1:0] default_duty(input logic [HOUR_W-1:0] row,
                                                     input logic [1:0] ch);
    return DEFAULT_PROFILE[row][ch];
  endfunction

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
    return (v > DUTY_MAX) ? DUTY_MAX : v;
  endfunction

endpackage

>>> rtl/hlsi_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module hlsi_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/hlsi_ctrl.sv
// Request decode, preview sequencer and table write control.
module hlsi_ctrl #(
  parameter int HOURS = hlsi_pkg::HOURS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       acc,
  input  logic [hlsi_pkg::ACT_W-1:0]  action,
  input  logic [hlsi_pkg::HOUR_W-1:0] hour,
  input  logic [hlsi_pkg::MIN_W-1:0]  minute,
  input  logic [hlsi_pkg::NUM_CH-1:0] mask,
  output hlsi_pkg::tick_info_t        tick,
  output hlsi_pkg::tbl_wr_t           wr,
  output logic                        is_tick
);

  import hlsi_pkg::*;

  localparam int RW = $clog2(HOURS);

  mode_t           mode, mode_next;
  logic [RW-1:0]   preview_hour, preview_hour_next;
  action_t         act;
  logic            still_on;
  logic [HOUR_W-1:0] row_raw;
  logic [RW-1:0]   row, nxt;

  assign act = action_t'(action);

  always_comb begin
    still_on = 1'b0;
    row_raw  = hour;
    if (mode == MODE_PREVIEW) begin
      row_raw  = HOUR_W'(preview_hour);
      still_on = (preview_hour < RW'(HOURS - 1));
    end
    // hours past the end of the day wrap round
    if (row_raw >= HOUR_W'(HOURS)) begin
      row = RW'(row_raw - HOUR_W'(HOURS));
    end else begin
      row = RW'(row_raw);
    end
    nxt = (row == RW'(HOURS - 1)) ? '0 : row + 1'b1;

    tick.row  = HOUR_W'(row);
    tick.nxt  = HOUR_W'(nxt);
    tick.prog = still_on ? PROG_FULL : minute;
    tick.pon  = still_on;
  end

  assign is_tick = (act == ACT_TICK);
  assign wr.row  = hour;
  assign wr.en   = (acc && act == ACT_WRITE && hour < HOUR_W'(HOURS)) ? mask : '0;

  always_comb begin
    mode_next         = mode;
    preview_hour_next = preview_hour;
    if (acc) begin
      unique case (act)
        ACT_TICK: begin
          if (mode == MODE_PREVIEW) begin
            if (still_on) begin
              preview_hour_next = preview_hour + 1'b1;
            end else begin
              mode_next         = MODE_LIVE;
              preview_hour_next = '0;
            end
          end
        end
        ACT_PREVIEW: begin
          mode_next         = MODE_PREVIEW;
          preview_hour_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LIVE;
      preview_hour <= '0;
    end else begin
      mode         <= mode_next;
      preview_hour <= preview_hour_next;
    end
  end

endmodule

>>> rtl/hlsi_lane.sv
// One colour channel: table storage and the three-stage blend pipeline.
module hlsi_lane #(
  parameter int HOURS = hlsi_pkg::HOURS_DEF,
  parameter int CH    = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hlsi_pkg::pipe_en_t         en,
  input  hlsi_pkg::tick_info_t       tick,
  input  logic                       wr_en,
  input  logic [hlsi_pkg::HOUR_W-1:0] wr_row,
  input  logic [hlsi_pkg::DUTY_W-1:0] wr_value,
  output logic [hlsi_pkg::DUTY_W-1:0] duty
);

  import hlsi_pkg::*;

  localparam int RW    = $clog2(HOURS);
  localparam int SUM_W = DUTY_W + 2;

  logic [HOURS-1:0]   valid;
  logic [RW-1:0]      waddr, cur_addr, nxt_addr;
  logic [DUTY_W-1:0]  ram_cur, ram_nxt;

  // stage 1
  logic               vcur1, vnxt1;
  logic [RW-1:0]      cur1, nxt1;
  logic [MIN_W-1:0]   prog1;
  logic [DUTY_W-1:0]  s_val, e_val, mag;
  logic               up, dn;
  logic [PROD_W-1:0]  prod;
  // stage 2
  logic [DUTY_W-1:0]  s2;
  logic               up2, dn2;
  logic [PROD_W-1:0]  prod2;
  logic [PROD_W+RECIP_W-1:0] qfull;
  // stage 3
  logic [DUTY_W-1:0]  s3;
  logic               up3, dn3;
  logic [Q_W-1:0]     q3;
  logic [SUM_W-1:0]   sum, dif;

  assign waddr    = RW'(wr_row);
  assign cur_addr = RW'(tick.row);
  assign nxt_addr = RW'(tick.nxt);

  // rows never written read back as the built-in profile
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[waddr] <= 1'b1;
    end
  end

  hlsi_ram #(
    .WIDTH (DUTY_W),
    .DEPTH (HOURS)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (waddr),
    .wdata   (sat_duty(wr_value)),
    .re      (en.s1),
    .raddr_a (cur_addr),
    .raddr_b (nxt_addr),
    .rdata_a (ram_cur),
    .rdata_b (ram_nxt)
  );

  always_ff @(posedge clk) begin
    if (en.s1) begin
      vcur1 <= valid[cur_addr];
      vnxt1 <= valid[nxt_addr];
      cur1  <= cur_addr;
      nxt1  <= nxt_addr;
      prog1 <= tick.prog;
    end
  end

  always_comb begin
    s_val = vcur1 ? ram_cur : default_duty(HOUR_W'(cur1), 2'(CH));
    e_val = vnxt1 ? ram_nxt : default_duty(HOUR_W'(nxt1), 2'(CH));
    up    = (e_val > s_val);
    dn    = (e_val < s_val);
    mag   = up ? (e_val - s_val) : (s_val - e_val);
    prod  = PROD_W'(prog1) * PROD_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2    <= s_val;
      up2   <= up;
      dn2   <= dn;
      prod2 <= prod;
    end
  end

  // divide by sixty through the reciprocal
  assign qfull = (PROD_W+RECIP_W)'(prod2) * (PROD_W+RECIP_W)'(RECIP_60);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3  <= s2;
      up3 <= up2;
      dn3 <= dn2;
      q3  <= qfull[RECIP_60_SHIFT +: Q_W];
    end
  end

  always_comb begin
    sum = SUM_W'(s3) + SUM_W'(q3);
    dif = SUM_W'(s3) - SUM_W'(q3);
    if (up3) begin
      duty = (sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(sum);
    end else if (dn3) begin
      duty = (q3 > Q_W'(s3)) ? '0 : DUTY_W'(dif);
    end else begin
      duty = s3;
    end
  end

endmodule

>>> rtl/hourly_light_schedule_interpolator.sv
// Top level of the hourly light schedule interpolator.
//
// Requests arrive on the s_ stream: s_tuser carries the action (tick, table
// write, start preview), s_tdata the hour, minute, temperature, write mask
// and the three write values. Only ticks give a result; it leaves on the m_
// stream with the white, blue and purple duties, the fan duty and the hour
// row shown, m_tuser flagging that preview is still running.
// Fan mode and manual fan duty are set through the cfg_ write channel,
// always ready; write it only while no tick is in flight.
// Path: a tick accepted on s_ passes table read, multiply, reciprocal divide
// by sixty, and add and clamp, each closed by a register, before m_tvalid.
// Throughput: one request per cycle; each stage only holds when the stage
// after it is full and held, so the input keeps taking requests while a
// result waits, until every stage is full.
// Table writes take effect for any tick accepted from the next cycle on.
// Reset: table rows read as the built-in daily profile (per-row valid bits
// cleared at once, no clearing sweep), preview off, fan in auto mode with a
// manual duty of zero, pipeline empty.
`include "hourly_light_schedule_interpolator_macros.svh"

module hourly_light_schedule_interpolator #(
  parameter int HOURS = hlsi_pkg::HOURS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // hour[4:0], minute[10:5], temp_tenths[22:11], channel_mask[25:23],
  // white_value[35:26], blue_value[45:36], purple_value[55:46]
  input  logic [hlsi_pkg::IN_DATA_W-1:0]    s_tdata,
  // action[1:0]
  input  logic [hlsi_pkg::ACT_W-1:0]        s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // white_duty[9:0], blue_duty[19:10], purple_duty[29:20], fan_duty[39:30],
  // shown_hour[44:40], zero fill[47:45]
  output logic [hlsi_pkg::OUT_DATA_W-1:0]   m_tdata,
  // preview_on[0]
  output logic [0:0]                        m_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hlsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hlsi_pkg::DUTY_W-1:0]       cfg_data
);

  import hlsi_pkg::*;

  // request fields
  logic [HOUR_W-1:0]  in_hour;
  logic [MIN_W-1:0]   in_minute;
  logic [TEMP_W-1:0]  in_temp;
  logic [NUM_CH-1:0]  in_mask;
  logic [DUTY_W-1:0]  in_value [NUM_CH];

  assign in_hour     = s_tdata[4:0];
  assign in_minute   = s_tdata[10:5];
  assign in_temp     = s_tdata[22:11];
  assign in_mask     = s_tdata[25:23];
  assign in_value[0] = s_tdata[35:26];
  assign in_value[1] = s_tdata[45:36];
  assign in_value[2] = s_tdata[55:46];

  // config registers
  logic               fan_manual;
  logic [DUTY_W-1:0]  fan_manual_duty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_manual      <= 1'b0;
      fan_manual_duty <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FAN_MANUAL: fan_manual      <= cfg_data[0];
        CFG_FAN_DUTY:   fan_manual_duty <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow: a stage loads when it is empty or its successor moves
  logic      v1, v2, v3, out_valid;
  logic      en_out;
  pipe_en_t  en;
  logic      acc, tick_acc, is_tick;

  assign en_out   = !out_valid || m_tready;
  assign en.s3    = !v3 || en_out;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;
  assign s_tready = en.s1;
  assign acc      = s_tvalid && s_tready;
  assign tick_acc = acc && is_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= tick_acc;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en_out) out_valid <= v3;
    end
  end

  tick_info_t tick;
  tbl_wr_t    wr;

  hlsi_ctrl #(
    .HOURS (HOURS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .action  (s_tuser),
    .hour    (in_hour),
    .minute  (in_minute),
    .mask    (in_mask),
    .tick    (tick),
    .wr      (wr),
    .is_tick (is_tick)
  );

  logic [DUTY_W-1:0] lane_duty [NUM_CH];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    hlsi_lane #(
      .HOURS (HOURS),
      .CH    (c)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tick     (tick),
      .wr_en    (wr.en[c]),
      .wr_row   (wr.row),
      .wr_value (in_value[c]),
      .duty     (lane_duty[c])
    );
  end

  // side data that rides alongside the lanes
  logic signed [TEMP_W-1:0] temp1;
  logic [HOUR_W-1:0]        row1, row2, row3;
  logic                     pon1, pon2, pon3;
  logic [DUTY_W-1:0]        fan2, fan3;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      temp1 <= in_temp;
      row1  <= tick.row;
      pon1  <= tick.pon;
    end
  end

  // auto fan: 0 below 40.0 C, full above 60.0 C, 50 per whole degree between
  logic [FAN_U_W-1:0]         fan_u;
  logic [2*FAN_U_W-1:0]       fan_p;
  logic [FAN_Q_W-1:0]         fan_q;
  logic [DUTY_W-1:0]          fan_auto, fan_sel;

  always_comb begin
    fan_u = FAN_U_W'(temp1 - TEMP_W'(FAN_ON_TENTHS));
    fan_p = (2*FAN_U_W)'(fan_u) * (2*FAN_U_W)'(RECIP_10);
    fan_q = fan_p[RECIP_10_SHIFT +: FAN_Q_W];
    // times fifty as 32 + 16 + 2
    fan_auto = {fan_q, 5'b0} + {1'b0, fan_q, 4'b0} + {4'b0, fan_q, 1'b0};
    if (temp1 > TEMP_W'(FAN_FULL_TENTHS)) begin
      fan_auto = DUTY_MAX;
    end else if (temp1 < TEMP_W'(FAN_ON_TENTHS)) begin
      fan_auto = '0;
    end
    fan_sel = fan_manual ? fan_manual_duty : fan_auto;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      fan2 <= fan_sel;
      row2 <= row1;
      pon2 <= pon1;
    end
    if (en.s3) begin
      fan3 <= fan2;
      row3 <= row2;
      pon3 <= pon2;
    end
  end

  // output register
  logic [DUTY_W-1:0] white_duty, blue_duty, purple_duty, fan_duty;
  logic [HOUR_W-1:0] shown_hour;
  logic              preview_on;

  always_ff @(posedge clk) begin
    if (en_out) begin
      white_duty  <= lane_duty[0];
      blue_duty   <= lane_duty[1];
      purple_duty <= lane_duty[2];
      fan_duty    <= fan3;
      shown_hour  <= row3;
      preview_on  <= pon3;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {3'b0, shown_hour, fan_duty, purple_duty, blue_duty, white_duty};
  assign m_tuser[0] = preview_on;

  `HLSI_ASSERT(a_duty_range, !m_tvalid || (white_duty <= DUTY_MAX && blue_duty <= DUTY_MAX && purple_duty <= DUTY_MAX), "light duty above full scale")
  `HLSI_ASSERT(a_preview_row, !(m_tvalid && preview_on) || shown_hour < HOUR_W'(HOURS - 1), "preview still on after last row")
  `HLSI_ASSERT_NEXT(a_tick_enters, tick_acc, v1, "accepted tick lost at pipeline entry")
  `HLSI_ASSERT_NEXT(a_stage3_held, v3 && !en.s3, v3, "held result dropped from last stage")

endmodule
